// ===== design/i2cms_pkg.sv =====
// Package for the I2C master bit sequencer.
// Holds the action, status and command codes, and the command descriptor type.
// No dependencies.
package i2cms_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;
   localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;
   localparam int BYTE_W = 8;

   localparam logic [2:0] ACT_START = 3'd0;
   localparam logic [2:0] ACT_STOP = 3'd1;
   localparam logic [2:0] ACT_SEND = 3'd2;
   localparam logic [2:0] ACT_BEGIN_ACK = 3'd3;
   localparam logic [2:0] ACT_ACK_SAMPLE = 3'd4;

   localparam logic [1:0] ACK_NONE = 2'd0;
   localparam logic [1:0] ACK_OK = 2'd1;
   localparam logic [1:0] ACK_TIMEOUT = 2'd2;

   typedef enum logic [2:0] {
      OP_START,
      OP_STOP,
      OP_SEND,
      OP_BEGIN,
      OP_ACKOK,
      OP_HOLD
   } op_type;

   typedef struct packed {
      op_type op;
      logic [BYTE_W-1:0] data;
      logic scl;
      logic sda;
      logic drive;
      logic [1:0] status;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== design/i2cms_front.sv =====
// Front end: accepts commands, tracks ack wait, miss count and held line state,
// and pushes one descriptor per command with a defined action code. Depends on i2cms_pkg.
module i2cms_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_action,
   input  logic [7:0]             req_tx_byte,
   input  logic                   req_sda_level,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data,
   input  i2cms_pkg::q_status_type q_status,
   output logic                   q_push,
   output i2cms_pkg::desc_type    q_wdata
);
   import i2cms_pkg::*;

   logic [7:0] limit_ff, limit_in;
   logic [7:0] miss_ff, miss_in, miss_inc;
   logic       await_ff, await_in;
   logic       scl_ff, scl_in, sda_ff, sda_in, drv_ff, drv_in;
   logic       accept;

   assign req_stall = q_status.full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !q_status.full;
   assign miss_inc  = (miss_ff == 8'hFF) ? miss_ff : miss_ff + 8'd1;

   always_comb begin
      limit_in = (csr_valid && csr_ready) ? csr_data : limit_ff;
      miss_in  = miss_ff;
      await_in = await_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      drv_in   = drv_ff;
      q_push   = 1'b0;
      q_wdata.op     = OP_HOLD;
      q_wdata.data   = req_tx_byte;
      q_wdata.scl    = scl_ff;
      q_wdata.sda    = sda_ff;
      q_wdata.drive  = drv_ff;
      q_wdata.status = ACK_NONE;
      if (accept) begin
         unique case (req_action)
            ACT_START: begin
               q_push = 1'b1;
               q_wdata.op = OP_START;
               await_in = 1'b0;
               {scl_in, sda_in, drv_in} = 3'b001;
            end
            ACT_STOP: begin
               q_push = 1'b1;
               q_wdata.op = OP_STOP;
               await_in = 1'b0;
               {scl_in, sda_in, drv_in} = 3'b111;
            end
            ACT_SEND: begin
               q_push = 1'b1;
               q_wdata.op = OP_SEND;
               await_in = 1'b0;
               {scl_in, sda_in, drv_in} = {1'b0, req_tx_byte[0], 1'b1};
            end
            ACT_BEGIN_ACK: begin
               q_push = 1'b1;
               q_wdata.op = OP_BEGIN;
               await_in = 1'b1;
               miss_in = '0;
               {scl_in, sda_in, drv_in} = 3'b110;
            end
            ACT_ACK_SAMPLE: begin
               q_push = 1'b1;
               if (!await_ff) begin
                  q_wdata.op = OP_HOLD;
               end else if (!req_sda_level) begin
                  q_wdata.op = OP_ACKOK;
                  q_wdata.status = ACK_OK;
                  await_in = 1'b0;
                  {scl_in, sda_in, drv_in} = 3'b010;
               end else begin
                  miss_in = miss_inc;
                  if (miss_inc > limit_ff) begin
                     q_wdata.op = OP_STOP;
                     q_wdata.status = ACK_TIMEOUT;
                     await_in = 1'b0;
                     {scl_in, sda_in, drv_in} = 3'b111;
                  end else begin
                     q_wdata.op = OP_HOLD;
                  end
               end
            end
            default: begin
               q_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ACK_LIMIT_RESET;
         miss_ff  <= '0;
         await_ff <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         drv_ff   <= 1'b1;
      end else begin
         limit_ff <= limit_in;
         miss_ff  <= miss_in;
         await_ff <= await_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         drv_ff   <= drv_in;
      end
   end

endmodule

// ===== design/i2cms_queue.sv =====
// Small register FIFO of command descriptors between front and back ends.
// Depends on i2cms_pkg.
module i2cms_queue #(
   parameter int DEPTH = i2cms_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  i2cms_pkg::desc_type     wdata,
   input  logic                    pop,
   output i2cms_pkg::desc_type     rdata,
   output i2cms_pkg::q_status_type status
);
   import i2cms_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== design/i2cms_back.sv =====
// Back end: expands one descriptor into line segments, one per cycle unless rsp_stall
// holds them back, into a registered output stage. Depends on i2cms_pkg.
module i2cms_back (
   input  logic                    clock,
   input  logic                    reset,
   input  i2cms_pkg::q_status_type q_status,
   input  i2cms_pkg::desc_type     q_rdata,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_scl,
   output logic                    rsp_sda_out,
   output logic                    rsp_sda_drive,
   output logic [1:0]              rsp_ack_status,
   output logic                    rsp_last
);
   import i2cms_pkg::*;

   typedef struct packed {
      logic scl;
      logic sda;
      logic drive;
      logic [1:0] status;
      logic last;
   } seg_type;

   desc_type   desc_ff, desc_in;
   logic       active_ff, active_in;
   logic [1:0] phase_ff, phase_in;
   logic [2:0] bit_ff, bit_in;
   logic       tail_ff, tail_in;
   logic       valid_ff, valid_in;
   seg_type    out_ff, seg;
   logic       load_ok, emit, bit_val;

   assign load_ok = !valid_ff || !rsp_stall;
   assign emit    = active_ff && load_ok;
   assign q_pop   = !q_status.empty && (!active_ff || (emit && seg.last));
   assign bit_val = desc_ff.data[bit_ff];

   always_comb begin
      seg = '{scl: 1'b0, sda: 1'b0, drive: 1'b1, status: ACK_NONE, last: 1'b0};
      unique case (desc_ff.op)
         OP_START: begin
            unique case (phase_ff)
               2'd0:    seg = '{1'b1, 1'b1, 1'b1, ACK_NONE, 1'b0};
               2'd1:    seg = '{1'b1, 1'b0, 1'b1, ACK_NONE, 1'b0};
               default: seg = '{1'b0, 1'b0, 1'b1, ACK_NONE, 1'b1};
            endcase
         end
         OP_STOP: begin
            unique case (phase_ff)
               2'd0:    seg = '{1'b0, 1'b0, 1'b1, ACK_NONE, 1'b0};
               2'd1:    seg = '{1'b1, 1'b0, 1'b1, ACK_NONE, 1'b0};
               default: seg = '{1'b1, 1'b1, 1'b1, desc_ff.status, 1'b1};
            endcase
         end
         OP_SEND: begin
            if (!tail_ff) begin
               seg = '{phase_ff == 2'd1, bit_val, 1'b1, ACK_NONE, 1'b0};
            end else begin
               seg = '{phase_ff == 2'd0, desc_ff.data[0], 1'b1, ACK_NONE,
                       phase_ff == 2'd1};
            end
         end
         OP_BEGIN: begin
            unique case (phase_ff)
               2'd0:    seg = '{1'b0, desc_ff.sda, desc_ff.drive, ACK_NONE, 1'b0};
               2'd1:    seg = '{1'b0, 1'b1, desc_ff.drive, ACK_NONE, 1'b0};
               default: seg = '{1'b1, 1'b1, 1'b0, ACK_NONE, 1'b1};
            endcase
         end
         OP_ACKOK: seg = '{1'b0, 1'b1, 1'b0, ACK_OK, 1'b1};
         default:  seg = '{desc_ff.scl, desc_ff.sda, desc_ff.drive, ACK_NONE, 1'b1};
      endcase
   end

   always_comb begin
      desc_in   = desc_ff;
      active_in = active_ff;
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      tail_in   = tail_ff;
      valid_in  = load_ok ? emit : valid_ff;
      if (emit) begin
         if (desc_ff.op == OP_SEND && !tail_ff && phase_ff == 2'd2) begin
            phase_in = 2'd0;
            if (bit_ff == 3'd0) begin
               tail_in = 1'b1;
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end else begin
            phase_in = phase_ff + 2'd1;
         end
         if (seg.last) begin
            active_in = 1'b0;
         end
      end
      if (q_pop) begin
         active_in = 1'b1;
         desc_in   = q_rdata;
         phase_in  = 2'd0;
         bit_in    = 3'd7;
         tail_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         phase_ff  <= 2'd0;
         bit_ff    <= 3'd7;
         tail_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         phase_ff  <= phase_in;
         bit_ff    <= bit_in;
         tail_ff   <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      if (emit) begin
         out_ff <= seg;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_scl        = out_ff.scl;
   assign rsp_sda_out    = out_ff.sda;
   assign rsp_sda_drive  = out_ff.drive;
   assign rsp_ack_status = out_ff.status;
   assign rsp_last       = out_ff.last;

endmodule

// ===== design/i2c_master_bit_sequencer_core.sv =====
// I2C master bit sequencer top: front end, descriptor queue, segment back end.
// The first segment of an accepted command passes the queue entry, desc_ff and out_ff.
// The back end gives one segment per cycle while rsp_stall is low; a command expands
// into 3 segments (start, stop, begin ack, timeout), 1 (ack sample) or 26 (send byte).
// Synchronous reset empties the queue, sets lines high and driven, limit 250.
module i2c_master_bit_sequencer_core #(
   parameter int QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [7:0] req_tx_byte,
   input  logic       req_sda_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl,
   output logic       rsp_sda_out,
   output logic       rsp_sda_drive,
   output logic [1:0] rsp_ack_status,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);
   import i2cms_pkg::*;

   q_status_type q_status;
   desc_type     q_wdata, q_rdata;
   logic         q_push, q_pop;

   i2cms_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_tx_byte   (req_tx_byte),
      .req_sda_level (req_sda_level),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_wdata       (q_wdata)
   );

   i2cms_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   i2cms_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_rdata        (q_rdata),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl        (rsp_scl),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_ack_status (rsp_ack_status),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ack_status != ACK_NONE |-> rsp_last)
      else $error("ack status on a non-final segment");

   a_released_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sda_drive |-> rsp_sda_out)
      else $error("released SDA not held high");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty at once");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");
`endif

endmodule

// ===== dv/i2cms_line_checker.sv =====
// Checker for the I2C master bit sequencer: watches command, segment and CSR traffic.
// Predicts the line segments of every accepted command and compares them in order.
// Depends on i2cms_pkg for the action and ack status codes.
module i2cms_line_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [7:0] req_tx_byte,
   input  logic       req_sda_level,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_scl,
   input  logic       rsp_sda_out,
   input  logic       rsp_sda_drive,
   input  logic [1:0] rsp_ack_status,
   input  logic       rsp_last,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [7:0] csr_data,
   output int         mismatches,
   output int         lines_due,
   output int         lines_seen,
   output int         acks_seen,
   output int         timeouts_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import i2cms_pkg::*;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       drive;
      logic [1:0] status;
      logic       last;
   } line_seg_type;

   line_seg_type seg_fifo[$];
   logic [7:0]   ack_limit;
   logic         held_scl;
   logic         held_sda;
   logic         held_drive;
   logic         ack_wait;
   logic [7:0]   miss_cnt;

   function automatic void put_seg(logic scl, logic sda, logic drive, logic [1:0] status,
                                   logic last);
      line_seg_type s;
      held_scl   = scl;
      held_sda   = sda;
      held_drive = drive;
      s = '{scl: scl, sda: sda, drive: drive, status: status, last: last};
      seg_fifo.push_back(s);
   endfunction

   function automatic void put_stop(logic [1:0] status);
      put_seg(1'b0, 1'b0, 1'b1, ACK_NONE, 1'b0);
      put_seg(1'b1, 1'b0, 1'b1, ACK_NONE, 1'b0);
      put_seg(1'b1, 1'b1, 1'b1, status, 1'b1);
   endfunction

   function automatic void predict_lines(logic [2:0] act, logic [7:0] byt, logic lvl);
      logic data_bit;
      logic drv;
      int   i;
      data_bit = 1'b0;
      unique case (act)
         ACT_START: begin
            ack_wait = 1'b0;
            put_seg(1'b1, 1'b1, 1'b1, ACK_NONE, 1'b0);
            put_seg(1'b1, 1'b0, 1'b1, ACK_NONE, 1'b0);
            put_seg(1'b0, 1'b0, 1'b1, ACK_NONE, 1'b1);
         end
         ACT_STOP: begin
            ack_wait = 1'b0;
            put_stop(ACK_NONE);
         end
         ACT_SEND: begin
            ack_wait = 1'b0;
            for (i = 7; i >= 0; i--) begin
               data_bit = byt[i];
               put_seg(1'b0, data_bit, 1'b1, ACK_NONE, 1'b0);
               put_seg(1'b1, data_bit, 1'b1, ACK_NONE, 1'b0);
               put_seg(1'b0, data_bit, 1'b1, ACK_NONE, 1'b0);
            end
            // ack clock pulse, ack ignored
            put_seg(1'b1, data_bit, 1'b1, ACK_NONE, 1'b0);
            put_seg(1'b0, data_bit, 1'b1, ACK_NONE, 1'b1);
         end
         ACT_BEGIN_ACK: begin
            drv = held_drive;
            put_seg(1'b0, held_sda, drv, ACK_NONE, 1'b0);
            put_seg(1'b0, 1'b1, drv, ACK_NONE, 1'b0);
            put_seg(1'b1, 1'b1, 1'b0, ACK_NONE, 1'b1);
            ack_wait = 1'b1;
            miss_cnt = '0;
         end
         ACT_ACK_SAMPLE: begin
            if (!ack_wait) begin
               put_seg(held_scl, held_sda, held_drive, ACK_NONE, 1'b1);
            end else if (!lvl) begin
               ack_wait = 1'b0;
               put_seg(1'b0, 1'b1, 1'b0, ACK_OK, 1'b1);
            end else begin
               if (miss_cnt != 8'hFF) miss_cnt++;
               if (miss_cnt > ack_limit) begin
                  ack_wait = 1'b0;
                  put_stop(ACK_TIMEOUT);
               end else begin
                  put_seg(held_scl, held_sda, held_drive, ACK_NONE, 1'b1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      line_seg_type want;
      if (reset) begin
         ack_limit     = ACK_LIMIT_RESET;
         held_scl      = 1'b1;
         held_sda      = 1'b1;
         held_drive    = 1'b1;
         ack_wait      = 1'b0;
         miss_cnt      = '0;
         mismatches    = 0;
         lines_seen    = 0;
         acks_seen     = 0;
         timeouts_seen = 0;
         seg_fifo.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            lines_seen++;
            if (rsp_ack_status == ACK_OK) acks_seen++;
            if (rsp_ack_status == ACK_TIMEOUT) timeouts_seen++;
            if (seg_fifo.size() == 0) begin
               $error("segment with none expected: scl %0d sda %0d drive %0d status %0d last %0d",
                      rsp_scl, rsp_sda_out, rsp_sda_drive, rsp_ack_status, rsp_last);
               mismatches++;
            end else begin
               want = seg_fifo.pop_front();
               check_field("scl", 2'(want.scl), 2'(rsp_scl));
               check_field("sda_out", 2'(want.sda), 2'(rsp_sda_out));
               check_field("sda_drive", 2'(want.drive), 2'(rsp_sda_drive));
               check_field("ack_status", want.status, rsp_ack_status);
               check_field("last", 2'(want.last), 2'(rsp_last));
            end
         end
         if (csr_valid && csr_ready) ack_limit = csr_data;
         if (req_valid && !req_stall) predict_lines(req_action, req_tx_byte, req_sda_level);
      end
      lines_due = seg_fifo.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for i2c_master_bit_sequencer_core: clock, reset, command and CSR stimulus.
// Segment prediction and comparison live in i2cms_line_checker; this module gives the verdict.
// Depends on i2cms_pkg, the core RTL and dv/i2cms_line_checker.sv.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cms_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS = 4;
   localparam int SAT_MISSES = 257;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_action;
   logic [7:0] req_tx_byte;
   logic       req_sda_level;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_scl;
   logic       rsp_sda_out;
   logic       rsp_sda_drive;
   logic [1:0] rsp_ack_status;
   logic       rsp_last;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;

   int         mismatches;
   int         lines_due;
   int         lines_seen;
   int         acks_seen;
   int         timeouts_seen;

   bit         idle_on = 1'b1;
   bit         hold_now = 1'b0;
   int         items_sent = 0;
   int         limits_set = 0;
   int         cycle_cnt = 0;
   logic [7:0] cur_limit = ACK_LIMIT_RESET;

   i2c_master_bit_sequencer_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_tx_byte    (req_tx_byte),
      .req_sda_level  (req_sda_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl        (rsp_scl),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_ack_status (rsp_ack_status),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   i2cms_line_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_tx_byte    (req_tx_byte),
      .req_sda_level  (req_sda_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl        (rsp_scl),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_ack_status (rsp_ack_status),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatches     (mismatches),
      .lines_due      (lines_due),
      .lines_seen     (lines_seen),
      .acks_seen      (acks_seen),
      .timeouts_seen  (timeouts_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d segments still due", cycle_cnt, lines_due);
         $display("TB_ERROR");
         $finish;
      end
   end

   // segment receiver: random stall bursts, one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_now) begin
            hold_now = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(99, 0) < 20) begin
            stall_left = $urandom_range(10, 1) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [7:0] pick_byte();
      unique case ($urandom_range(9, 0))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h01;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic int gap_cycles();
      if (idle_on && $urandom_range(99, 0) < 30) return $urandom_range(10, 1);
      return 0;
   endfunction

   task automatic push_cmd(input logic [2:0] act, input logic [7:0] byt, input logic lvl);
      int gap;
      gap = gap_cycles();
      repeat (gap) begin
         @(negedge clock);
         req_valid     <= 1'b0;
         req_action    <= 3'($urandom);
         req_tx_byte   <= 8'($urandom);
         req_sda_level <= 1'($urandom);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_action    <= act;
      req_tx_byte   <= byt;
      req_sda_level <= lvl;
      do @(posedge clock); while (req_stall);
      if (act <= ACT_ACK_SAMPLE) items_sent++;
   endtask

   // drop valid, let every due segment drain, then allow for ignored items in flight
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (lines_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [7:0] val);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_limit = val;
      limits_set++;
   endtask

   task automatic run_transfer();
      int nbytes;
      int misses;
      int k;
      int j;
      if ($urandom_range(99, 0) < 85) begin
         push_cmd(ACT_START, pick_byte(), 1'($urandom));
         nbytes = $urandom_range(3, 1);
         for (k = 0; k < nbytes; k++) begin
            push_cmd(ACT_SEND, pick_byte(), 1'($urandom));
            push_cmd(ACT_BEGIN_ACK, pick_byte(), 1'($urandom));
            misses = (cur_limit <= 8'd6) ? $urandom_range(cur_limit + 2, 0)
                                         : $urandom_range(4, 0);
            for (j = 0; j < misses; j++) push_cmd(ACT_ACK_SAMPLE, pick_byte(), 1'b1);
            if ($urandom_range(99, 0) < 75) push_cmd(ACT_ACK_SAMPLE, pick_byte(), 1'b0);
         end
         if ($urandom_range(99, 0) < 85) push_cmd(ACT_STOP, pick_byte(), 1'($urandom));
      end else begin
         for (k = $urandom_range(3, 1); k > 0; k--)
            push_cmd(3'($urandom_range(7, 0)), pick_byte(), 1'($urandom));
      end
   endtask

   initial begin
      logic [7:0] phase_limit [6];
      int p;
      int goal;
      int j;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_START;
      req_tx_byte   = '0;
      req_sda_level = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      phase_limit = '{8'd0, 8'd1, 8'($urandom_range(254, 7)), 8'd255,
                      8'($urandom_range(6, 2)), 8'($urandom)};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset limit
      push_cmd(ACT_ACK_SAMPLE, 8'h00, 1'b0);
      push_cmd(ACT_ACK_SAMPLE, 8'hFF, 1'b1);
      push_cmd(ACT_START, 8'h00, 1'b0);
      push_cmd(ACT_SEND, 8'h00, 1'b0);
      push_cmd(ACT_SEND, 8'hFF, 1'b1);
      push_cmd(ACT_SEND, 8'h80, 1'b0);
      push_cmd(ACT_SEND, 8'h01, 1'b1);
      push_cmd(ACT_BEGIN_ACK, 8'h00, 1'b1);
      push_cmd(ACT_ACK_SAMPLE, 8'h00, 1'b1);
      push_cmd(ACT_ACK_SAMPLE, 8'h00, 1'b1);
      push_cmd(ACT_ACK_SAMPLE, 8'h00, 1'b0);
      push_cmd(ACT_ACK_SAMPLE, 8'h00, 1'b1);
      push_cmd(ACT_BEGIN_ACK, 8'h00, 1'b0);
      push_cmd(ACT_ACK_SAMPLE, 8'h00, 1'b1);
      push_cmd(ACT_START, 8'h00, 1'b1);
      push_cmd(ACT_ACK_SAMPLE, 8'h00, 1'b1);
      push_cmd(ACT_SEND, 8'h5A, 1'b0);
      push_cmd(ACT_BEGIN_ACK, 8'h00, 1'b0);
      push_cmd(ACT_SEND, 8'hA5, 1'b1);
      push_cmd(ACT_ACK_SAMPLE + 3'd1, 8'hFF, 1'b1);
      push_cmd(ACT_ACK_SAMPLE + 3'd2, 8'h00, 1'b0);
      push_cmd(ACT_ACK_SAMPLE + 3'd3, 8'hFF, 1'b1);
      push_cmd(ACT_BEGIN_ACK, 8'h00, 1'b0);
      push_cmd(ACT_STOP, 8'h00, 1'b0);
      push_cmd(ACT_STOP, 8'h00, 1'b1);

      for (p = 0; p < 6; p++) begin
         write_limit(phase_limit[p]);
         if (p == 2) hold_now = 1'b1;
         if (p == 5) idle_on = 1'b0;
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) run_transfer();
         if (cur_limit == 8'd255) begin
            // miss count saturates and must never time out
            push_cmd(ACT_BEGIN_ACK, pick_byte(), 1'b1);
            for (j = 0; j < SAT_MISSES; j++) push_cmd(ACT_ACK_SAMPLE, pick_byte(), 1'b1);
            push_cmd(ACT_ACK_SAMPLE, pick_byte(), 1'b0);
         end
      end

      settle();
      repeat (12) @(negedge clock);
      $display("Sent %0d commands over %0d ack-limit writes plus the reset limit.",
               items_sent, limits_set);
      $display("Checked %0d line segments: %0d acks, %0d timeouts, %0d mismatches.",
               lines_seen, acks_seen, timeouts_seen, mismatches);
      if (mismatches == 0 && lines_due == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/i2cms_pkg.sv
design/i2cms_front.sv
design/i2cms_queue.sv
design/i2cms_back.sv
design/i2c_master_bit_sequencer_core.sv
dv/i2cms_line_checker.sv
dv/tb_top.sv
